[rtl/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types, widths and character codes of the signed decimal formatter
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int VALUE_W       = 32;  // input integer width
    localparam int CHAR_W        = 8;   // ascii byte
    localparam int CFG_W         = 6;   // widest configuration register
    localparam int CFG_IDX_W     = 3;   // register index width
    localparam int BCD_DIGITS    = 10;  // decimal digits of a 32-bit magnitude
    localparam int DEF_MAX_FIELD = 40;  // saturation point of width and precision

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WIDTH  = 3'd0,
        CFG_PRECISION  = 3'd1,
        CFG_PREC_ON    = 3'd2,
        CFG_LEFT_ALIGN = 3'd3,
        CFG_ZERO_PAD   = 3'd4,
        CFG_FORCE_PLUS = 3'd5,
        CFG_SPACE_SIGN = 3'd6
    } t_cfg_idx;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item, start conversion
        logic step;     // one double-dabble iteration
        logic measure;  // digit count and sign
        logic size;     // precision zeros and pad length
        logic bound;    // segment boundaries and character count
        logic emit;     // load next character into output register
    } t_sdf_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;    // item prints no characters
        logic final_ch; // next character to emit is the last one
    } t_sdf_sts;

endpackage

[rtl/sdf_dp.sv]
// ----------------------------------------------------------------------------
// sdf_dp
// datapath: configuration registers, binary to bcd conversion, layout
// arithmetic and character selection with the output register
// ----------------------------------------------------------------------------
module sdf_dp import sdf_pkg::*; #(
    parameter int MAX_FIELD = DEF_MAX_FIELD
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [VALUE_W-1:0]   i_value,
    input  t_sdf_cmd             i_cmd,
    output t_sdf_sts             o_sts,
    output logic [CHAR_W-1:0]    o_character,
    output logic                 o_last
);

    localparam int CW    = $clog2(MAX_FIELD + 2);  // holds up to MAX_FIELD + 1 characters
    localparam int DIG_W = $clog2(BCD_DIGITS + 1);
    localparam int BCD_W = 4 * BCD_DIGITS;

    // configuration
    logic [CFG_W-1:0] r_min_width;
    logic [CFG_W-1:0] r_prec_val;
    logic             r_prec_on;
    logic             r_left;
    logic             r_zero_pad;
    logic             r_force_plus;
    logic             r_space_sign;

    // conversion
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic               r_neg;

    // layout
    logic [DIG_W-1:0]  r_ndig;
    logic [CHAR_W-1:0] r_sign_ch;
    logic              r_has_sign;
    logic              r_zf;
    logic [CW-1:0]     r_lz;
    logic [CW-1:0]     r_pad;
    logic [CW-1:0]     r_b1, r_b2, r_b4, r_b5, r_n;
    logic [CW-1:0]     r_k;

    // output register payload
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic [CFG_W-1:0]  field_max;
    logic [CW-1:0]     width_c, prec_c;
    logic [BCD_W-1:0]  bcd_adj;
    logic [DIG_W-1:0]  hi_c, ndig_c;
    logic [CW-1:0]     ndig_w, lz_c, total_c, pad_c;
    logic [CW-1:0]     b1_c, b2_c, b3_c, b4_c, b5_c, n_c;
    logic [CW-1:0]     didx_c;
    logic [3:0]        digit_c;
    logic [CHAR_W-1:0] char_c;
    logic [VALUE_W-1:0] mag_c;

    // saturate width and precision
    always_comb begin
        field_max = CFG_W'(MAX_FIELD);
        width_c   = CW'((r_min_width > field_max) ? field_max : r_min_width);
        prec_c    = CW'((r_prec_val  > field_max) ? field_max : r_prec_val);
    end

    assign mag_c = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;

    // add 3 to each bcd digit of 5 or more before the shift
    always_comb begin
        for (int j = 0; j < BCD_DIGITS; j++) begin
            bcd_adj[4*j +: 4] = (r_bcd[4*j +: 4] >= 4'd5) ?
                                (r_bcd[4*j +: 4] + 4'd3) : r_bcd[4*j +: 4];
        end
    end

    // highest nonzero digit
    always_comb begin
        hi_c = '0;
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (r_bcd[4*j +: 4] != 4'd0) begin
                hi_c = DIG_W'(j + 1);
            end
        end
        // zero with an explicit zero precision prints no digits
        if (hi_c != '0) begin
            ndig_c = hi_c;
        end else if (r_prec_on && (prec_c == '0)) begin
            ndig_c = '0;
        end else begin
            ndig_c = DIG_W'(1);
        end
    end

    // precision zeros and pad
    always_comb begin
        ndig_w  = CW'(r_ndig);
        lz_c    = (r_prec_on && (prec_c > ndig_w)) ? (prec_c - ndig_w) : '0;
        total_c = ndig_w + lz_c + CW'(r_has_sign);
        pad_c   = (width_c > total_c) ? (width_c - total_c) : '0;
    end

    // segment ends: spaces, sign, fill zeros, precision zeros, digits, trailing
    always_comb begin
        b1_c = (!r_left && !r_zf) ? r_pad : '0;
        b2_c = b1_c + CW'(r_has_sign);
        b3_c = b2_c + (r_zf ? r_pad : '0);
        b4_c = b3_c + r_lz;
        b5_c = b4_c + CW'(r_ndig);
        n_c  = b5_c + (r_left ? r_pad : '0);
    end

    // character at position r_k
    always_comb begin
        didx_c  = r_b5 - r_k - CW'(1);
        digit_c = '0;
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (didx_c == CW'(j)) begin
                digit_c = r_bcd[4*j +: 4];
            end
        end
        if (r_k < r_b1) begin
            char_c = CH_SPACE;
        end else if (r_k < r_b2) begin
            char_c = r_sign_ch;
        end else if (r_k < r_b4) begin
            char_c = CH_ZERO;
        end else if (r_k < r_b5) begin
            char_c = CH_ZERO + CHAR_W'(digit_c);
        end else begin
            char_c = CH_SPACE;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width  <= '0;
            r_prec_val   <= '0;
            r_prec_on    <= 1'b0;
            r_left       <= 1'b0;
            r_zero_pad   <= 1'b0;
            r_force_plus <= 1'b0;
            r_space_sign <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_WIDTH:  r_min_width  <= i_cfg_wdata;
                CFG_PRECISION:  r_prec_val   <= i_cfg_wdata;
                CFG_PREC_ON:    r_prec_on    <= i_cfg_wdata[0];
                CFG_LEFT_ALIGN: r_left       <= i_cfg_wdata[0];
                CFG_ZERO_PAD:   r_zero_pad   <= i_cfg_wdata[0];
                CFG_FORCE_PLUS: r_force_plus <= i_cfg_wdata[0];
                CFG_SPACE_SIGN: r_space_sign <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= mag_c;
            r_bcd <= '0;
            r_neg <= i_value[VALUE_W-1];
        end else if (i_cmd.step) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
        end
        if (i_cmd.measure) begin
            r_ndig     <= ndig_c;
            r_has_sign <= r_neg | r_force_plus | r_space_sign;
            r_sign_ch  <= r_neg ? CH_MINUS : (r_force_plus ? CH_PLUS : CH_SPACE);
            r_zf       <= r_zero_pad & ~r_prec_on & ~r_left;
        end
        if (i_cmd.size) begin
            r_lz  <= lz_c;
            r_pad <= pad_c;
        end
        if (i_cmd.bound) begin
            r_b1 <= b1_c;
            r_b2 <= b2_c;
            r_b4 <= b4_c;
            r_b5 <= b5_c;
            r_n  <= n_c;
            r_k  <= '0;
        end else if (i_cmd.emit) begin
            r_char <= char_c;
            r_last <= (r_k == r_n - CW'(1));
            r_k    <= r_k + CW'(1);
        end
    end

    assign o_sts.empty    = (r_n == '0);
    assign o_sts.final_ch = (r_k == r_n - CW'(1));
    assign o_character    = r_char;
    assign o_last         = r_last;

endmodule

[rtl/sdf_ctrl.sv]
// ----------------------------------------------------------------------------
// sdf_ctrl
// controller: sequences conversion, layout and character emission, and owns
// the valid bit of the output register
// ----------------------------------------------------------------------------
module sdf_ctrl import sdf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_sdf_sts i_sts,
    output t_sdf_cmd o_cmd
);

    localparam int BIT_W = $clog2(VALUE_W);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CONV  = 6'b000010,
        S_MEAS  = 6'b000100,
        S_SIZE  = 6'b001000,
        S_BOUND = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                n_bit      = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(VALUE_W - 1)) begin
                    n_state = S_MEAS;
                end
            end
            S_MEAS: begin
                o_cmd.measure = 1'b1;
                n_state       = S_SIZE;
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = S_BOUND;
            end
            S_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.empty) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.final_ch) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/signed_decimal_formatter.sv]
// ----------------------------------------------------------------------------
// signed_decimal_formatter
// prints a signed 32-bit integer as ascii text in printf %d style
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready with i_value, one item per integer
//   output channel: o_out_valid / i_out_ready, one item per character;
//     o_last marks the final character of an integer
//   config port: i_cfg_wr_en, i_cfg_index, i_cfg_wdata; write only while idle
//     0 min_width, 1 precision, 2 precision on, 3 left align, 4 zero pad,
//     5 force plus, 6 space sign; other indexes are ignored
//   order: shift-add-3 conversion of the 32 input bits, then the measure,
//     size and bound layout states, then the first character is loaded
//     into the output register once that register is free
//   throughput: an integer prints up to MAX_FIELD + 1 characters, one
//     character per cycle while the receiver keeps up; a new integer is
//     taken only once the previous one is fully done
//   an integer that prints nothing yields no output item at all
//   reset: synchronous active low; clears the controller, the output valid
//     and all configuration registers to zero
//   stall: the output register holds its character while i_out_ready is low;
//     emission pauses and no new integer is taken until the last character
//     is loaded, after which a new integer is taken even if it still waits
// ----------------------------------------------------------------------------
module signed_decimal_formatter import sdf_pkg::*; #(
    parameter int MAX_FIELD = DEF_MAX_FIELD
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // integer input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [VALUE_W-1:0]   i_value,
    // character output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAR_W-1:0]    o_character,
    output logic                 o_last
);

    t_sdf_cmd cmd;  // controller commands
    t_sdf_sts sts;  // datapath status

    // sequencer: idle, conversion, layout, emission
    sdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // configuration, bcd conversion and character generation
    sdf_dp #(
        .MAX_FIELD (MAX_FIELD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

[rtl/sdf_chk.sv]
// ----------------------------------------------------------------------------
// sdf_chk
// port level checks of the signed decimal formatter, bound to the top level
// ----------------------------------------------------------------------------
module sdf_chk import sdf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last
);

    // a waiting character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_character) && $stable(o_last))
        else $error("output item changed while stalled");

    // after an accept, conversion keeps the input closed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input reopened during conversion");

    // no new item is taken in the middle of a character string
    a_no_accept_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready before last character");

endmodule

bind signed_decimal_formatter sdf_chk u_sdf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_character (o_character),
    .o_last      (o_last)
);
